// ===== rtl/core/coordinate_rms_deviation_macros.svh =====
// ============================================================================
// coordinate_rms_deviation_macros.svh
// Assertion macros shared by the RMS deviation RTL. They compile to nothing
// when SYNTHESIS is defined.
// ============================================================================
`ifndef COORDINATE_RMS_DEVIATION_MACROS_SVH
`define COORDINATE_RMS_DEVIATION_MACROS_SVH
`ifndef SYNTHESIS
// Check a property at every clock edge outside reset
`define CRD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition is followed by another in the next cycle
`define CRD_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define CRD_ASSERT(lbl, clk, rst_n, prop, msg)
`define CRD_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== rtl/core/crd_pkg.sv =====
// ============================================================================
// crd_pkg
// Types and fixed constants of the coordinate RMS deviation block.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package crd_pkg;

    // Fixed field widths
    localparam int IndexBits = 10;
    localparam int CountBits = 11;
    localparam int SumBits   = 64;
    localparam int RmsBits   = 25;
    localparam int RootBits  = SumBits / 2;

    // Queue between front and back
    localparam int QueueDepth = 4;
    localparam int QueueAw    = $clog2(QueueDepth);

    // Sequencer step counts
    localparam int DivSteps  = SumBits;
    localparam int SqrtSteps = RootBits;
    localparam int StepBits  = $clog2(DivSteps);

    // Dummy atom threshold: 9998.0 in Q8, compared strictly greater
    localparam logic signed [32:0] DummyLimit = 33'sd2559488;

    localparam logic [CountBits-1:0] CountMax = '1;

    // Divide / square root sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } t_root_state;

    // Request from the accumulator to the divide / square root unit
    typedef struct packed {
        logic                 start;
        logic [SumBits-1:0]   sum;
        logic [CountBits-1:0] count;
        logic                 dummy;
    } t_root_req;

    // Add two 64-bit values, clamping at all ones
    function automatic logic [SumBits-1:0] sat_add(input logic [SumBits-1:0] a,
                                                   input logic [SumBits-1:0] b);
        logic [SumBits:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SumBits] ? {SumBits{1'b1}} : s[SumBits-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/crd_if.sv =====
// ============================================================================
// crd_if
// Valid/ready channels of the RMS deviation block: atom requests in and
// result requests out.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface crd_item_if #(
    parameter int COORD_BITS = 24
);
    logic                               valid;
    logic                               ready;
    logic                               mode;
    logic [crd_pkg::IndexBits-1:0]      atom_index;
    logic signed [COORD_BITS-1:0]       coord_x;
    logic signed [COORD_BITS-1:0]       coord_y;
    logic signed [COORD_BITS-1:0]       coord_z;
    logic                               is_last;

    modport source (output valid, mode, atom_index, coord_x, coord_y, coord_z, is_last,
                    input ready);
    modport sink   (input valid, mode, atom_index, coord_x, coord_y, coord_z, is_last,
                    output ready);
endinterface

interface crd_result_if;
    logic                           valid;
    logic                           ready;
    logic [crd_pkg::RmsBits-1:0]    rms_value;
    logic [crd_pkg::CountBits-1:0]  atom_count;
    logic                           reference_has_dummy;

    modport source (output valid, rms_value, atom_count, reference_has_dummy,
                    input ready);
    modport sink   (input valid, rms_value, atom_count, reference_has_dummy,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/crd_ram.sv =====
// ============================================================================
// crd_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module crd_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/core/crd_queue.sv =====
// ============================================================================
// crd_queue
// Small register FIFO that decouples the atom front end from the
// accumulator back end.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "coordinate_rms_deviation_macros.svh"

module crd_queue #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 4,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_data,
    output logic      [AW:0]      o_free
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;

    // Store pushed requests
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_free  = (AW+1)'(DEPTH) - r_count;

    `CRD_ASSERT(a_queue_no_overflow, i_clk, i_rst_n, !(i_push && (r_count == (AW+1)'(DEPTH))), "queue push while full")
    `CRD_ASSERT(a_queue_no_underflow, i_clk, i_rst_n, !(i_pop && (r_count == '0)), "queue pop while empty")

endmodule

`default_nettype wire

// ===== rtl/core/crd_front.sv =====
// ============================================================================
// crd_front
// Front end: accepts atom requests, writes reference atoms and tracks the
// dummy flag, and reads the reference for compare requests into the queue.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module crd_front #(
    parameter  int COORD_BITS = 24,
    parameter  int MAX_ATOMS  = 1024,
    localparam int QW         = 6 * COORD_BITS + 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    crd_item_if.sink                      i_item,
    input  wire logic [crd_pkg::QueueAw:0] i_q_free,
    output logic                          o_q_push,
    output logic      [QW-1:0]            o_q_data
);

    localparam int RefSpan  = 1 << crd_pkg::IndexBits;
    localparam int RefDepth = (MAX_ATOMS < RefSpan) ? MAX_ATOMS : RefSpan;
    localparam int RamAw    = (RefDepth > 1) ? $clog2(RefDepth) : 1;
    localparam int RefW     = 3 * COORD_BITS;
    localparam logic [31:0] AtomLimit = 32'(MAX_ATOMS);

    logic                    accept;
    logic                    idx_ok;
    logic                    load;
    logic                    cmp;
    logic                    is_dummy;
    logic signed [32:0]      ext_x;
    logic signed [32:0]      ext_y;
    logic signed [32:0]      ext_z;
    logic [RamAw-1:0]        ram_addr;
    logic [RefW-1:0]         ram_q;
    logic                    n_dummy;

    logic                    r_dummy;
    logic                    r_stg_v;
    logic                    r_stg_ok;
    logic                    r_stg_last;
    logic                    r_stg_dummy;
    logic [COORD_BITS-1:0]   r_stg_x;
    logic [COORD_BITS-1:0]   r_stg_y;
    logic [COORD_BITS-1:0]   r_stg_z;

    // Leave room in the queue for the request already in the read stage
    assign i_item.ready = (i_q_free > (crd_pkg::QueueAw+1)'(r_stg_v));
    assign accept       = i_item.valid && i_item.ready;
    assign idx_ok       = (32'(i_item.atom_index) < AtomLimit);
    assign load         = accept && !i_item.mode && idx_ok;
    assign cmp          = accept && i_item.mode;
    assign ram_addr     = i_item.atom_index[RamAw-1:0];

    // Classify dummy atoms: all three coordinates above the limit
    always_comb begin
        ext_x    = 33'(i_item.coord_x);
        ext_y    = 33'(i_item.coord_y);
        ext_z    = 33'(i_item.coord_z);
        is_dummy = (ext_x > crd_pkg::DummyLimit) && (ext_y > crd_pkg::DummyLimit)
                && (ext_z > crd_pkg::DummyLimit);
        n_dummy  = r_dummy;
        if (load) begin
            n_dummy = ((i_item.atom_index == '0) ? 1'b0 : r_dummy) | is_dummy;
        end
    end

    // Reference coordinate store
    crd_ram #(
        .WIDTH (RefW),
        .DEPTH (RefDepth)
    ) u_ref_ram (
        .i_clk     (i_clk),
        .i_wr_en   (load),
        .i_wr_addr (ram_addr),
        .i_wr_data ({i_item.coord_x, i_item.coord_y, i_item.coord_z}),
        .i_rd_en   (cmp),
        .i_rd_addr (ram_addr),
        .o_rd_data (ram_q)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dummy <= 1'b0;
            r_stg_v <= 1'b0;
        end else begin
            r_dummy <= n_dummy;
            r_stg_v <= cmp;
        end
    end

    // Hold compare payload while the reference is read
    always_ff @(posedge i_clk) begin
        if (cmp) begin
            r_stg_ok    <= idx_ok;
            r_stg_last  <= i_item.is_last;
            r_stg_dummy <= r_dummy;
            r_stg_x     <= i_item.coord_x;
            r_stg_y     <= i_item.coord_y;
            r_stg_z     <= i_item.coord_z;
        end
    end

    // Push compare request with its reference; out-of-range reads as zero
    assign o_q_push = r_stg_v;
    assign o_q_data = {r_stg_last, r_stg_dummy, r_stg_x, r_stg_y, r_stg_z,
                       (r_stg_ok ? ram_q : {RefW{1'b0}})};

endmodule

`default_nettype wire

// ===== rtl/core/crd_back.sv =====
// ============================================================================
// crd_back
// Back end: squared distance pipeline and saturating accumulator. Hands the
// sum and count of a finished conformation to the divide / root unit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "coordinate_rms_deviation_macros.svh"

module crd_back #(
    parameter  int COORD_BITS = 24,
    localparam int QW         = 6 * COORD_BITS + 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire logic [QW-1:0] i_q_data,
    output logic               o_q_pop,
    input  wire logic          i_root_idle,
    output crd_pkg::t_root_req o_req
);

    localparam int DW = COORD_BITS + 1;
    localparam int SW = crd_pkg::SumBits;
    localparam int CW = crd_pkg::CountBits;

    logic [COORD_BITS-1:0]   cur [3];
    logic [COORD_BITS-1:0]   refv [3];
    logic signed [DW-1:0]    ea [3];
    logic signed [DW-1:0]    eb [3];
    logic signed [DW-1:0]    dp [3];
    logic signed [DW-1:0]    dn [3];
    logic [DW-1:0]           mag [3];
    logic                    last_in_pipe;
    logic [SW-1:0]           n_sum;
    logic [CW-1:0]           n_cnt;

    logic                    r_s1_v, r_s2_v, r_s3_v, r_s4_v;
    logic                    r_s1_last, r_s2_last, r_s3_last, r_s4_last;
    logic                    r_s1_dummy, r_s2_dummy, r_s3_dummy, r_s4_dummy;
    logic [31:0]             r_s1_mag [3];
    logic                    r_s1_over [3];
    logic [SW-1:0]           r_s2_sq [3];
    logic [SW-1:0]           r_s3_xy;
    logic [SW-1:0]           r_s3_z;
    logic [SW-1:0]           r_s4_d;
    logic [SW-1:0]           r_sum;
    logic [CW-1:0]           r_cnt;

    // Take requests only while the root unit is idle and no conformation end is in flight
    assign last_in_pipe = (r_s1_v && r_s1_last) || (r_s2_v && r_s2_last)
                       || (r_s3_v && r_s3_last) || (r_s4_v && r_s4_last);
    assign o_q_pop      = i_q_valid && i_root_idle && !last_in_pipe;

    // Unpack queue entry and form absolute differences per axis
    always_comb begin
        cur[0]  = i_q_data[6*COORD_BITS-1 -: COORD_BITS];
        cur[1]  = i_q_data[5*COORD_BITS-1 -: COORD_BITS];
        cur[2]  = i_q_data[4*COORD_BITS-1 -: COORD_BITS];
        refv[0] = i_q_data[3*COORD_BITS-1 -: COORD_BITS];
        refv[1] = i_q_data[2*COORD_BITS-1 -: COORD_BITS];
        refv[2] = i_q_data[COORD_BITS-1 -: COORD_BITS];
        for (int i = 0; i < 3; i++) begin
            ea[i]  = DW'($signed(cur[i]));
            eb[i]  = DW'($signed(refv[i]));
            dp[i]  = ea[i] - eb[i];
            dn[i]  = eb[i] - ea[i];
            mag[i] = dp[i][DW-1] ? dn[i] : dp[i];
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            r_s1_v <= o_q_pop;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
        end
    end

    // Distance datapath: magnitude, square, two saturating adds
    always_ff @(posedge i_clk) begin
        r_s1_last  <= i_q_data[QW-1];
        r_s1_dummy <= i_q_data[QW-2];
        for (int i = 0; i < 3; i++) begin
            r_s1_mag[i]  <= 32'(mag[i]);
            r_s1_over[i] <= (64'(mag[i]) > 64'hFFFF_FFFF);
        end
        r_s2_last  <= r_s1_last;
        r_s2_dummy <= r_s1_dummy;
        for (int i = 0; i < 3; i++) begin
            r_s2_sq[i] <= r_s1_over[i] ? {SW{1'b1}}
                        : ({32'b0, r_s1_mag[i]} * {32'b0, r_s1_mag[i]});
        end
        r_s3_last  <= r_s2_last;
        r_s3_dummy <= r_s2_dummy;
        r_s3_xy    <= crd_pkg::sat_add(r_s2_sq[0], r_s2_sq[1]);
        r_s3_z     <= r_s2_sq[2];
        r_s4_last  <= r_s3_last;
        r_s4_dummy <= r_s3_dummy;
        r_s4_d     <= crd_pkg::sat_add(r_s3_xy, r_s3_z);
    end

    // Accumulate; on the last atom hand off and clear
    always_comb begin
        n_sum = crd_pkg::sat_add(r_sum, r_s4_d);
        n_cnt = (r_cnt == crd_pkg::CountMax) ? r_cnt : r_cnt + CW'(1);
        o_req.start = r_s4_v && r_s4_last;
        o_req.sum   = n_sum;
        o_req.count = n_cnt;
        o_req.dummy = r_s4_dummy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (r_s4_v) begin
            if (r_s4_last) begin
                r_sum <= '0;
                r_cnt <= '0;
            end else begin
                r_sum <= n_sum;
                r_cnt <= n_cnt;
            end
        end
    end

    `CRD_ASSERT(a_start_when_idle, i_clk, i_rst_n, o_req.start |-> i_root_idle, "root unit busy at start")
    `CRD_ASSERT(a_single_last, i_clk, i_rst_n, $countones({r_s1_v && r_s1_last, r_s2_v && r_s2_last, r_s3_v && r_s3_last, r_s4_v && r_s4_last}) <= 1, "two conformation ends in flight")

endmodule

`default_nettype wire

// ===== rtl/core/crd_root.sv =====
// ============================================================================
// crd_root
// Sequencer for the mean and root: restoring divide of the sum by the count,
// one quotient bit a cycle, then a digit-by-digit integer square root, one
// result bit a cycle. Holds the result until the receiver takes it.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "coordinate_rms_deviation_macros.svh"

module crd_root (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire crd_pkg::t_root_req i_req,
    output logic                    o_idle,
    crd_result_if.source            o_result
);

    localparam int SW = crd_pkg::SumBits;
    localparam int CW = crd_pkg::CountBits;
    localparam int RW = crd_pkg::RootBits;
    localparam int TW = crd_pkg::StepBits;
    localparam int MW = RW + 1;

    crd_pkg::t_root_state r_state, n_state;

    logic [TW-1:0]   r_step, n_step;
    logic [CW-1:0]   r_rem_d, n_rem_d;
    logic [SW-1:0]   r_quo, n_quo;
    logic [CW-1:0]   r_den, n_den;
    logic            r_dummy, n_dummy;
    logic [MW-1:0]   r_rem_s, n_rem_s;
    logic [RW-1:0]   r_root, n_root;

    logic [CW:0]     div_rs;
    logic [CW:0]     div_diff;
    logic            div_ge;
    logic [MW+1:0]   sq_rs;
    logic [MW+1:0]   sq_trial;
    logic [MW+2:0]   sq_diff;
    logic            sq_ok;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crd_pkg::ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_rem_d <= n_rem_d;
        r_quo   <= n_quo;
        r_den   <= n_den;
        r_dummy <= n_dummy;
        r_rem_s <= n_rem_s;
        r_root  <= n_root;
    end

    // One divide step and one root step
    always_comb begin
        div_rs   = {r_rem_d, r_quo[SW-1]};
        div_diff = div_rs - {1'b0, r_den};
        div_ge   = (div_rs >= {1'b0, r_den});
        sq_rs    = {r_rem_s, r_quo[SW-1 -: 2]};
        sq_trial = {1'b0, r_root, 2'b01};
        sq_diff  = {1'b0, sq_rs} - {1'b0, sq_trial};
        sq_ok    = !sq_diff[MW+2];
    end

    // Next state and outputs
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_rem_d = r_rem_d;
        n_quo   = r_quo;
        n_den   = r_den;
        n_dummy = r_dummy;
        n_rem_s = r_rem_s;
        n_root  = r_root;
        o_idle         = 1'b0;
        o_result.valid = 1'b0;
        unique case (r_state)
            crd_pkg::ST_IDLE: begin
                o_idle = 1'b1;
                if (i_req.start) begin
                    n_quo   = i_req.sum;
                    n_den   = i_req.count;
                    n_dummy = i_req.dummy;
                    n_rem_d = '0;
                    n_step  = '0;
                    n_state = crd_pkg::ST_DIV;
                end
            end
            crd_pkg::ST_DIV: begin
                n_rem_d = div_ge ? div_diff[CW-1:0] : div_rs[CW-1:0];
                n_quo   = {r_quo[SW-2:0], div_ge};
                n_step  = r_step + TW'(1);
                if (r_step == TW'(crd_pkg::DivSteps - 1)) begin
                    n_step  = '0;
                    n_rem_s = '0;
                    n_root  = '0;
                    n_state = crd_pkg::ST_SQRT;
                end
            end
            crd_pkg::ST_SQRT: begin
                n_rem_s = sq_ok ? sq_diff[MW-1:0] : sq_rs[MW-1:0];
                n_root  = {r_root[RW-2:0], sq_ok};
                n_quo   = {r_quo[SW-3:0], 2'b00};
                n_step  = r_step + TW'(1);
                if (r_step == TW'(crd_pkg::SqrtSteps - 1)) begin
                    n_step  = '0;
                    n_state = crd_pkg::ST_DONE;
                end
            end
            crd_pkg::ST_DONE: begin
                o_result.valid = 1'b1;
                if (o_result.ready) begin
                    n_state = crd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = crd_pkg::ST_IDLE;
            end
        endcase
    end

    // Clamp root to the result width
    assign o_result.rms_value = (r_root[RW-1:crd_pkg::RmsBits] != '0)
                              ? {crd_pkg::RmsBits{1'b1}} : r_root[crd_pkg::RmsBits-1:0];
    assign o_result.atom_count          = r_den;
    assign o_result.reference_has_dummy = r_dummy;

    `CRD_ASSERT(a_den_nonzero, i_clk, i_rst_n, (r_state == crd_pkg::ST_DIV) |-> (r_den != '0), "divide by zero count")
    `CRD_ASSERT(a_done_after_root, i_clk, i_rst_n, $rose(o_result.valid) |-> ($past(r_state) == crd_pkg::ST_SQRT), "result without root pass")
    `CRD_ASSERT_NEXT(a_start_taken, i_clk, i_rst_n, (r_state == crd_pkg::ST_IDLE) && i_req.start, r_state == crd_pkg::ST_DIV, "start request lost")

endmodule

`default_nettype wire

// ===== rtl/core/coordinate_rms_deviation.sv =====
// ============================================================================
// coordinate_rms_deviation
// RMS deviation of atom coordinates against a stored reference set.
// ============================================================================
// Use: requests arrive on i_item (valid/ready). mode 0 stores a reference
// atom at atom_index (index 0 clears the dummy flag); mode 1 compares an atom
// against the reference at its index and adds the squared distance to the
// running sum. A mode 1 request with is_last produces one result on o_result:
// floor(sqrt(sum / count)) in Q8, the atom count and the dummy flag.
// Throughput: one atom request per cycle while a conformation streams in and the queue has room.
// Path of a last atom, with the sequencer free: the reference read register,
// the queue, the distance stages and the hand-off, then 64 divide steps and
// 32 root steps in the bit-serial divide/root unit.
// While it runs the accumulator holds off, the 4-entry queue fills and the
// input then stalls; reference loads pass only when the queue has room.
// Reset clears the sum, count, flag, queue and sequencer; the reference
// store is not cleared and must be loaded before an index is compared.
// A stalled receiver keeps the result held; the back end waits and the
// input stalls once the queue is full.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module coordinate_rms_deviation #(
    parameter int MAX_ATOMS  = 1024,
    parameter int COORD_BITS = 24
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    crd_item_if.sink     i_item,
    crd_result_if.source o_result
);

    localparam int QW = 6 * COORD_BITS + 2;

    logic                          q_push;
    logic [QW-1:0]                 q_in;
    logic                          q_pop;
    logic                          q_valid;
    logic [QW-1:0]                 q_out;
    logic [crd_pkg::QueueAw:0]     q_free;
    logic                          root_idle;
    crd_pkg::t_root_req            root_req;

    // Accept and classify requests
    crd_front #(
        .COORD_BITS (COORD_BITS),
        .MAX_ATOMS  (MAX_ATOMS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_q_free (q_free),
        .o_q_push (q_push),
        .o_q_data (q_in)
    );

    // Decouple front and back
    crd_queue #(
        .WIDTH (QW),
        .DEPTH (crd_pkg::QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out),
        .o_free  (q_free)
    );

    // Squared distances and accumulation
    crd_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_out),
        .o_q_pop     (q_pop),
        .i_root_idle (root_idle),
        .o_req       (root_req)
    );

    // Mean and square root per conformation
    crd_root u_root (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (root_req),
        .o_idle   (root_idle),
        .o_result (o_result)
    );

endmodule

`default_nettype wire
